### hw/rtl/ssacf_pkg.sv
`timescale 1ns / 1ps

package ssacf_pkg;

	localparam int ID_W   = 10;
	localparam int VAL_W  = 16;
	localparam int CMD_W  = 3;
	localparam int OP_W   = 3;
	localparam int CNT_W  = 3;
	localparam int CFG_W  = 11;
	localparam int ERR_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PHI_FIELDS = 4;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PLAIN = 3'd1;
	localparam logic [CMD_W-1:0] CMD_OP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PHI   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_AND = 3'd2;
	localparam logic [OP_W-1:0] OP_OR  = 3'd3;
	localparam logic [OP_W-1:0] OP_XOR = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OP    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_PHI   = 2'd3;

	localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;
	localparam logic [CFG_W-1:0]   TABLE_SIZE_RST  = 11'd1024;

	typedef struct packed {
		logic             known;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_DONE
	} state_t;

	function automatic logic [VAL_W-1:0] fold(input logic [OP_W-1:0] op,
			input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] r;
		case (op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_AND: r = a & b;
			OP_OR:  r = a | b;
			default: r = a ^ b;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/ssacf_ram.sv
`timescale 1ns / 1ps

module ssacf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ssa_constant_folding_table.sv
`timescale 1ns / 1ps

// Constant folding table for SSA values. Each request defines, folds, merges (phi) or reads
// one entry of a table held in a single RAM with one read and one write port, or clears the
// whole table. Entries are read one per cycle. After reset and after every clear request the
// block runs a clearing pass, writing one entry a cycle, and accepts no request meanwhile;
// the clear result itself is delivered before the pass starts. Errors are sticky until the
// next clear, and later define requests are then answered without effect.
module ssa_constant_folding_table #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int MAX_OPERANDS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ssacf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ssacf_pkg::CMD_W-1:0]    cmd,
	input  logic [ssacf_pkg::ID_W-1:0]     value_id,
	input  logic                           has_constant,
	input  logic [ssacf_pkg::VAL_W-1:0]    constant_value,
	input  logic                           operation_valid,
	input  logic [ssacf_pkg::OP_W-1:0]     operation,
	input  logic [ssacf_pkg::CNT_W-1:0]    operand_count,
	input  logic [ssacf_pkg::ID_W-1:0]     operand_0,
	input  logic [ssacf_pkg::ID_W-1:0]     operand_1,
	input  logic [ssacf_pkg::ID_W-1:0]     operand_2,
	input  logic [ssacf_pkg::ID_W-1:0]     operand_3,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ssacf_pkg::ID_W-1:0]     entry_id,
	output logic                           known,
	output logic [ssacf_pkg::VAL_W-1:0]    entry_value,
	output logic                           error,
	output logic [ssacf_pkg::ERR_W-1:0]    error_code
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PHI_LIMIT = (MAX_OPERANDS < ssacf_pkg::PHI_FIELDS) ?
		MAX_OPERANDS : ssacf_pkg::PHI_FIELDS;
	localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	ssacf_pkg::state_t state_q, state_d;

	logic [AW-1:0]                  sweep_q;
	logic [ssacf_pkg::CFG_W-1:0]    table_size_q;
	logic                           failed_q;
	logic [ssacf_pkg::ERR_W-1:0]    fail_code_q;

	// latched request
	logic [ssacf_pkg::CMD_W-1:0]    cmd_q;
	logic [ssacf_pkg::ID_W-1:0]     id_q;
	logic                           own_known_q;
	logic [ssacf_pkg::VAL_W-1:0]    own_val_q;
	logic                           op_valid_q;
	logic [ssacf_pkg::OP_W-1:0]     op_q;
	logic [ssacf_pkg::CNT_W-1:0]    count_q;
	logic [ssacf_pkg::ID_W-1:0]     opnd_q [ssacf_pkg::PHI_FIELDS];

	// read loop
	logic [ssacf_pkg::CNT_W-1:0]    n_q;
	logic [ssacf_pkg::CNT_W-1:0]    iss_q;
	logic                           pend_s1;
	logic [1:0]                     idx_s1;
	ssacf_pkg::entry_t              a_q;
	logic [ssacf_pkg::VAL_W-1:0]    first_q;

	// result being built
	logic                           res_known_q;
	logic [ssacf_pkg::VAL_W-1:0]    res_val_q;
	logic                           res_wr_q;
	logic                           res_fail_q;
	logic [ssacf_pkg::ERR_W-1:0]    res_code_q;

	// output register
	logic                           out_valid_q;
	logic [ssacf_pkg::ID_W-1:0]     out_id_q;
	logic                           out_known_q;
	logic [ssacf_pkg::VAL_W-1:0]    out_val_q;
	logic                           out_err_q;
	logic [ssacf_pkg::ERR_W-1:0]    out_code_q;

	logic                           in_fire;
	logic                           push;
	logic                           cfg_write;
	logic                           id_ok;
	logic                           op_bad;
	logic [ssacf_pkg::CNT_W-1:0]    phi_n;
	logic                           chk_read;
	logic                           ev_done;
	logic                           ev_prior;
	logic                           ev_last;
	logic [ssacf_pkg::ID_W-1:0]     ev_opnd;
	logic [ssacf_pkg::ID_W-1:0]     rd_sel;
	logic [ssacf_pkg::VAL_W-1:0]    res_val_norm;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	ssacf_pkg::entry_t              ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	ssacf_pkg::entry_t              ram_rdata;

	ssacf_ram #(
		.WIDTH ($bits(ssacf_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration port
	assign cfg_write = psel && penable && pwrite && (paddr == ssacf_pkg::ADDR_TABLE_SIZE);
	assign pready = 1'b1;
	assign prdata = (paddr == ssacf_pkg::ADDR_TABLE_SIZE) ? 32'(table_size_q) : '0;

	// request checks
	assign id_ok = (17'(id_q) < DEPTH_L) && (11'(id_q) < table_size_q);
	assign op_bad = !op_valid_q || (count_q != 3'd2) || (op_q > ssacf_pkg::OP_XOR) ||
		(opnd_q[0] >= id_q) || (opnd_q[1] >= id_q);
	assign phi_n = (count_q > 3'(PHI_LIMIT)) ? 3'(PHI_LIMIT) : count_q;

	always_comb begin
		chk_read = 1'b0;
		case (cmd_q)
			ssacf_pkg::CMD_READ: chk_read = id_ok;
			ssacf_pkg::CMD_OP:   chk_read = !failed_q && id_ok && !op_bad;
			ssacf_pkg::CMD_PHI:  chk_read = !failed_q && id_ok && (count_q != '0);
			default:             chk_read = 1'b0;
		endcase
	end

	// evaluation of the entry returned by the RAM
	assign ev_opnd  = opnd_q[idx_s1];
	assign ev_prior = ev_opnd < id_q;
	assign ev_last  = ({1'b0, idx_s1} == (n_q - 3'd1));

	always_comb begin
		ev_done = 1'b0;
		if (pend_s1) begin
			case (cmd_q)
				ssacf_pkg::CMD_OP: ev_done = (idx_s1 != 2'd0);
				ssacf_pkg::CMD_PHI: begin
					if (!ev_prior) begin
						ev_done = 1'b1;
					end else if (idx_s1 == 2'd0) begin
						ev_done = !ram_rdata.known || ev_last;
					end else begin
						ev_done = !ram_rdata.known || (ram_rdata.value != first_q) || ev_last;
					end
				end
				default: ev_done = 1'b1;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssacf_pkg::ST_SWEEP: if (sweep_q == LAST_ADDR) state_d = ssacf_pkg::ST_IDLE;
			ssacf_pkg::ST_IDLE:  if (in_valid) state_d = ssacf_pkg::ST_CHECK;
			ssacf_pkg::ST_CHECK: state_d = chk_read ? ssacf_pkg::ST_READ : ssacf_pkg::ST_DONE;
			ssacf_pkg::ST_READ:  if (ev_done) state_d = ssacf_pkg::ST_DONE;
			ssacf_pkg::ST_DONE: begin
				if (push) begin
					state_d = (cmd_q == ssacf_pkg::CMD_CLEAR) ?
						ssacf_pkg::ST_SWEEP : ssacf_pkg::ST_IDLE;
				end
			end
			default: state_d = ssacf_pkg::ST_SWEEP;
		endcase
	end

	// FSM outputs and RAM controls
	assign rd_sel = (cmd_q == ssacf_pkg::CMD_READ) ? id_q : opnd_q[iss_q[1:0]];
	assign res_val_norm = res_known_q ? res_val_q : '0;

	always_comb begin
		in_ready  = (state_q == ssacf_pkg::ST_IDLE);
		push      = (state_q == ssacf_pkg::ST_DONE) && (!out_valid_q || out_ready);
		ram_raddr = AW'(rd_sel);
		if (state_q == ssacf_pkg::ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end else begin
			ram_we          = push && res_wr_q;
			ram_waddr       = AW'(id_q);
			ram_wdata.known = res_known_q;
			ram_wdata.value = res_val_norm;
		end
	end

	assign in_fire = in_valid && in_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ssacf_pkg::ST_SWEEP;
			sweep_q      <= '0;
			table_size_q <= ssacf_pkg::TABLE_SIZE_RST;
			failed_q     <= 1'b0;
			fail_code_q  <= ssacf_pkg::ERR_NONE;
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				table_size_q <= pwdata[ssacf_pkg::CFG_W-1:0];
			end
			if (state_q == ssacf_pkg::ST_SWEEP) begin
				sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + AW'(1);
			end
			case (state_q)
				ssacf_pkg::ST_CHECK: begin
					iss_q   <= '0;
					pend_s1 <= 1'b0;
				end
				ssacf_pkg::ST_READ: begin
					pend_s1 <= (iss_q < n_q);
					if (iss_q < n_q) begin
						iss_q <= iss_q + 3'd1;
					end
				end
				default: pend_s1 <= 1'b0;
			endcase
			if (push) begin
				if (cmd_q == ssacf_pkg::CMD_CLEAR) begin
					failed_q    <= 1'b0;
					fail_code_q <= ssacf_pkg::ERR_NONE;
					sweep_q     <= '0;
				end else if (res_fail_q) begin
					failed_q    <= 1'b1;
					fail_code_q <= res_code_q;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q       <= cmd;
			id_q        <= value_id;
			own_known_q <= has_constant;
			own_val_q   <= constant_value;
			op_valid_q  <= operation_valid;
			op_q        <= operation;
			count_q     <= operand_count;
			opnd_q[0]   <= operand_0;
			opnd_q[1]   <= operand_1;
			opnd_q[2]   <= operand_2;
			opnd_q[3]   <= operand_3;
		end
		if (state_q == ssacf_pkg::ST_READ) begin
			idx_s1 <= iss_q[1:0];
		end
		case (state_q)
			ssacf_pkg::ST_CHECK: begin
				res_val_q <= own_val_q;
				case (cmd_q)
					ssacf_pkg::CMD_PHI: n_q <= phi_n;
					ssacf_pkg::CMD_OP:  n_q <= 3'd2;
					default:            n_q <= 3'd1;
				endcase
				if (cmd_q == ssacf_pkg::CMD_CLEAR || cmd_q >= ssacf_pkg::CMD_READ ||
						failed_q) begin
					res_known_q <= 1'b0;
					res_wr_q    <= 1'b0;
					res_fail_q  <= 1'b0;
					res_code_q  <= ssacf_pkg::ERR_NONE;
				end else if (!id_ok) begin
					res_known_q <= 1'b0;
					res_wr_q    <= 1'b0;
					res_fail_q  <= 1'b1;
					res_code_q  <= ssacf_pkg::ERR_RANGE;
				end else if (cmd_q == ssacf_pkg::CMD_OP && op_bad) begin
					res_known_q <= 1'b0;
					res_wr_q    <= 1'b0;
					res_fail_q  <= 1'b1;
					res_code_q  <= ssacf_pkg::ERR_OP;
				end else begin
					res_known_q <= own_known_q;
					res_wr_q    <= 1'b1;
					res_fail_q  <= 1'b0;
					res_code_q  <= ssacf_pkg::ERR_NONE;
				end
			end
			ssacf_pkg::ST_READ: begin
				if (pend_s1) begin
					case (cmd_q)
						ssacf_pkg::CMD_READ: begin
							res_known_q <= ram_rdata.known;
							res_val_q   <= ram_rdata.value;
						end
						ssacf_pkg::CMD_OP: begin
							if (idx_s1 == 2'd0) begin
								a_q <= ram_rdata;
							end else if (a_q.known && ram_rdata.known) begin
								res_known_q <= 1'b1;
								res_val_q   <= ssacf_pkg::fold(op_q, a_q.value, ram_rdata.value);
							end
						end
						ssacf_pkg::CMD_PHI: begin
							if (!ev_prior) begin
								res_known_q <= 1'b0;
								res_wr_q    <= 1'b0;
								res_fail_q  <= 1'b1;
								res_code_q  <= ssacf_pkg::ERR_PHI;
							end else if (idx_s1 == 2'd0) begin
								// unknown first operand keeps the value's own constant
								if (ram_rdata.known) begin
									first_q     <= ram_rdata.value;
									res_known_q <= 1'b1;
									res_val_q   <= ram_rdata.value;
								end
							end else if (!ram_rdata.known || ram_rdata.value != first_q) begin
								res_known_q <= 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		if (push) begin
			out_id_q    <= id_q;
			out_known_q <= res_known_q;
			out_val_q   <= res_val_norm;
			if (cmd_q == ssacf_pkg::CMD_CLEAR) begin
				out_err_q  <= 1'b0;
				out_code_q <= ssacf_pkg::ERR_NONE;
			end else if (res_fail_q) begin
				out_err_q  <= 1'b1;
				out_code_q <= res_code_q;
			end else begin
				out_err_q  <= failed_q;
				out_code_q <= fail_code_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_id    = out_id_q;
	assign known       = out_known_q;
	assign entry_value = out_val_q;
	assign error       = out_err_q;
	assign error_code  = out_code_q;

	// entries are only written while the analysis is healthy
	a_write_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssacf_pkg::ST_DONE && ram_we) |-> !failed_q)
		else $error("table entry written after failure");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error == (error_code != ssacf_pkg::ERR_NONE)))
		else $error("error flag and code disagree");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !known) |-> (entry_value == '0))
		else $error("unknown entry carries a value");

	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd_q == ssacf_pkg::CMD_CLEAR) |=> (state_q == ssacf_pkg::ST_SWEEP && !failed_q))
		else $error("clear did not start a clearing pass");

endmodule

### dv/ssa_constant_folding_table_tb.sv
`timescale 1ns / 1ps

module ssa_constant_folding_table_tb;

	localparam int TBL       = 1024;
	localparam int MAX_OPND  = 4;
	localparam int ID_MAX    = 1023;

	typedef struct packed {
		logic [ssacf_pkg::CMD_W-1:0]                            cmd;
		logic [ssacf_pkg::ID_W-1:0]                             id;
		logic                                                   has_const;
		logic [ssacf_pkg::VAL_W-1:0]                            cval;
		logic                                                   op_valid;
		logic [ssacf_pkg::OP_W-1:0]                             op;
		logic [ssacf_pkg::CNT_W-1:0]                            count;
		logic [ssacf_pkg::PHI_FIELDS-1:0][ssacf_pkg::ID_W-1:0]  opnd;
	} request_t;

	typedef struct packed {
		logic [ssacf_pkg::ID_W-1:0]  id;
		logic                        known;
		logic [ssacf_pkg::VAL_W-1:0] value;
		logic                        error;
		logic [ssacf_pkg::ERR_W-1:0] code;
	} result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ssacf_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [ssacf_pkg::CMD_W-1:0]    cmd;
	logic [ssacf_pkg::ID_W-1:0]     value_id;
	logic                           has_constant;
	logic [ssacf_pkg::VAL_W-1:0]    constant_value;
	logic                           operation_valid;
	logic [ssacf_pkg::OP_W-1:0]     operation;
	logic [ssacf_pkg::CNT_W-1:0]    operand_count;
	logic [ssacf_pkg::ID_W-1:0]     operand_0;
	logic [ssacf_pkg::ID_W-1:0]     operand_1;
	logic [ssacf_pkg::ID_W-1:0]     operand_2;
	logic [ssacf_pkg::ID_W-1:0]     operand_3;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [ssacf_pkg::ID_W-1:0]     entry_id;
	logic                           known;
	logic [ssacf_pkg::VAL_W-1:0]    entry_value;
	logic                           error;
	logic [ssacf_pkg::ERR_W-1:0]    error_code;

	request_t cur_req = '0;

	assign cmd             = cur_req.cmd;
	assign value_id        = cur_req.id;
	assign has_constant    = cur_req.has_const;
	assign constant_value  = cur_req.cval;
	assign operation_valid = cur_req.op_valid;
	assign operation       = cur_req.op;
	assign operand_count   = cur_req.count;
	assign operand_0       = cur_req.opnd[0];
	assign operand_1       = cur_req.opnd[1];
	assign operand_2       = cur_req.opnd[2];
	assign operand_3       = cur_req.opnd[3];

	ssa_constant_folding_table dut (.*);

	// shadow copy of the constant table
	logic                         known_tbl [TBL];
	logic [ssacf_pkg::VAL_W-1:0]  value_tbl [TBL];
	logic                         fold_failed;
	logic [ssacf_pkg::ERR_W-1:0]  fold_code;
	logic [ssacf_pkg::CFG_W-1:0]  size_cfg;

	request_t pending_reqs [$];
	result_t  expected_entries [$];
	int       prior_ids [$];
	int       n_sent = 0;
	int       n_taken = 0;
	int       n_bad = 0;
	int       send_idle_pct = 7;
	int       recv_idle_pct = 68;

	logic [ssacf_pkg::VAL_W-1:0] const_pool [5] =
		'{16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'h00FF};
	int phase_size  [9] = '{1024, 64, 0, 700, 1, 1024, 2, 1000, 1024};
	int phase_items [9] = '{300, 250, 40, 300, 40, 300, 60, 300, 260};

	function automatic result_t fold_entry(request_t r);
		result_t                     res;
		int                          lim, n, i;
		logic [ssacf_pkg::ERR_W-1:0] err;
		logic                        kn, stop;
		logic [ssacf_pkg::VAL_W-1:0] v, a, b, head;
		res = '0;
		res.id = r.id;
		lim = (size_cfg < TBL) ? int'(size_cfg) : TBL;
		if (r.cmd == ssacf_pkg::CMD_CLEAR) begin
			foreach (known_tbl[k]) known_tbl[k] = 1'b0;
			fold_failed = 1'b0;
			fold_code = ssacf_pkg::ERR_NONE;
			return res;
		end
		if (r.cmd >= ssacf_pkg::CMD_READ) begin
			// reads still answer after a failure; unused commands look like an unknown entry
			if (r.cmd == ssacf_pkg::CMD_READ && r.id < lim && known_tbl[r.id]) begin
				res.known = 1'b1;
				res.value = value_tbl[r.id];
			end
		end else if (!fold_failed) begin
			err = ssacf_pkg::ERR_NONE;
			kn = r.has_const;
			v = r.cval;
			if (r.id >= lim) begin
				err = ssacf_pkg::ERR_RANGE;
			end else if (r.cmd == ssacf_pkg::CMD_OP) begin
				if (!r.op_valid || r.count != 2 || r.op > ssacf_pkg::OP_XOR ||
						r.opnd[0] >= r.id || r.opnd[1] >= r.id) begin
					err = ssacf_pkg::ERR_OP;
				end else if (known_tbl[r.opnd[0]] && known_tbl[r.opnd[1]]) begin
					a = value_tbl[r.opnd[0]];
					b = value_tbl[r.opnd[1]];
					case (r.op)
						ssacf_pkg::OP_ADD: v = a + b;
						ssacf_pkg::OP_SUB: v = a - b;
						ssacf_pkg::OP_AND: v = a & b;
						ssacf_pkg::OP_OR:  v = a | b;
						default:           v = a ^ b;
					endcase
					kn = 1'b1;
				end
			end else if (r.cmd == ssacf_pkg::CMD_PHI && r.count != 0) begin
				n = (r.count > MAX_OPND) ? MAX_OPND : int'(r.count);
				if (r.opnd[0] >= r.id) begin
					err = ssacf_pkg::ERR_PHI;
				end else if (known_tbl[r.opnd[0]]) begin
					head = value_tbl[r.opnd[0]];
					stop = 1'b0;
					// first unknown or differing operand ends the scan
					for (i = 0; i < n; i++) begin
						if (!stop) begin
							if (r.opnd[i] >= r.id) begin
								err = ssacf_pkg::ERR_PHI;
								stop = 1'b1;
							end else if (!known_tbl[r.opnd[i]] ||
									value_tbl[r.opnd[i]] != head) begin
								kn = 1'b0;
								stop = 1'b1;
							end else begin
								kn = 1'b1;
								v = head;
							end
						end
					end
				end
			end
			if (err != ssacf_pkg::ERR_NONE) begin
				fold_failed = 1'b1;
				fold_code = err;
			end else begin
				known_tbl[r.id] = kn;
				value_tbl[r.id] = kn ? v : '0;
				res.known = kn;
				res.value = kn ? v : '0;
			end
		end
		res.error = fold_failed;
		res.code = fold_code;
		return res;
	endfunction

	function automatic request_t make_req(logic [ssacf_pkg::CMD_W-1:0] c,
			logic [ssacf_pkg::ID_W-1:0] id, logic hc, logic [ssacf_pkg::VAL_W-1:0] cv,
			logic ov, logic [ssacf_pkg::OP_W-1:0] op, logic [ssacf_pkg::CNT_W-1:0] cnt,
			logic [ssacf_pkg::ID_W-1:0] o0, logic [ssacf_pkg::ID_W-1:0] o1,
			logic [ssacf_pkg::ID_W-1:0] o2, logic [ssacf_pkg::ID_W-1:0] o3);
		request_t r;
		r.cmd = c;
		r.id = id;
		r.has_const = hc;
		r.cval = cv;
		r.op_valid = ov;
		r.op = op;
		r.count = cnt;
		r.opnd[0] = o0;
		r.opnd[1] = o1;
		r.opnd[2] = o2;
		r.opnd[3] = o3;
		return r;
	endfunction

	function automatic int pick_prior(int id);
		if (prior_ids.size() != 0 && $urandom_range(9) != 0)
			return prior_ids[$urandom_range(prior_ids.size() - 1)];
		return (id > 0) ? int'($urandom_range(id - 1)) : 0;
	endfunction

	task automatic apb_write(input logic [ssacf_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ssacf_pkg::ADDR_TABLE_SIZE)
			size_cfg = data[ssacf_pkg::CFG_W-1:0];
	endtask

	task automatic wait_table_idle();
		while (pending_reqs.size() != 0 || n_taken != n_sent || expected_entries.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request side
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_entries.push_back(fold_entry(cur_req));
			n_taken++;
		end
	end

	always @(negedge clk) begin
		if (n_taken == n_sent) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				n_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		result_t seen, want;
		if (out_valid && out_ready) begin
			seen = {entry_id, known, entry_value, error, error_code};
			if (expected_entries.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: id %0d known %0b value %h error %0b code %0d",
						seen.id, seen.known, seen.value, seen.error, seen.code);
			end else begin
				want = expected_entries.pop_front();
				if (seen !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"mismatch: want id %0d known %0b value %h error %0b code %0d, ",
							"got id %0d known %0b value %h error %0b code %0d"},
							want.id, want.known, want.value, want.error, want.code,
							seen.id, seen.known, seen.value, seen.error, seen.code);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		request_t    r;
		logic [95:0] bits;
		int          next_id, seg_left, pick, lim;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		foreach (known_tbl[k]) known_tbl[k] = 1'b0;
		fold_failed = 1'b0;
		fold_code = ssacf_pkg::ERR_NONE;
		size_cfg = ssacf_pkg::TABLE_SIZE_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_write(ssacf_pkg::ADDR_TABLE_SIZE, 32'(ssacf_pkg::TABLE_SIZE_RST));

		// directed: folds with wrap, unknown operands, phi corners, errors and clear
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, 0, 1, 16'hFFFF, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, 1, 1, 16'h0001, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 2, 0, 16'h0000, 1,
			ssacf_pkg::OP_ADD, 2, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 3, 0, 16'h0000, 1,
			ssacf_pkg::OP_SUB, 2, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 4, 0, 16'h0000, 1,
			ssacf_pkg::OP_AND, 2, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 5, 0, 16'h0000, 1,
			ssacf_pkg::OP_OR, 2, 0, 3, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 6, 0, 16'h0000, 1,
			ssacf_pkg::OP_XOR, 2, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, 7, 0, 16'h1234, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 8, 1, 16'hBEEF, 1,
			ssacf_pkg::OP_ADD, 2, 7, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 9, 1, 16'h5555, 0,
			ssacf_pkg::OP_ADD, 0, ID_MAX, ID_MAX, ID_MAX, ID_MAX));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 10, 1, 16'hAAAA, 0,
			ssacf_pkg::OP_ADD, 2, 7, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 11, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 4, 0, 5, 0, 5));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 12, 1, 16'h0F0F, 0,
			ssacf_pkg::OP_ADD, 3, 0, 1, ID_MAX, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 13, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 7, 11, 0, 5, 11));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 14, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 4, 2, 2, 2, 7));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_READ, 3, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_READ + 3'd1, 0, 1, 16'hFFFF, 1,
			ssacf_pkg::OP_ADD, 2, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 15, 0, 16'h0000, 0,
			ssacf_pkg::OP_XOR, 2, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, 16, 1, 16'h1111, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_READ, 0, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_CLEAR, ID_MAX, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, ID_MAX, 1, 16'h8000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PLAIN, 3, 1, 16'h0F0F, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_PHI, 4, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 2, 3, 9, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_CLEAR, 0, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_OP, 6, 0, 16'h0000, 1,
			ssacf_pkg::OP_XOR + 3'd1, 2, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(ssacf_pkg::CMD_CLEAR, 0, 0, 16'h0000, 0,
			ssacf_pkg::OP_ADD, 0, 0, 0, 0, 0));
		wait_table_idle();

		for (int p = 0; p < 9; p++) begin
			send_idle_pct = (p < 3) ? 7 : (p < 6) ? 68 : 0;
			recv_idle_pct = (p < 3) ? 68 : (p < 6) ? 7 : 0;
			apb_write(ssacf_pkg::ADDR_TABLE_SIZE, 32'(phase_size[p]));
			lim = (phase_size[p] < TBL) ? phase_size[p] : TBL;
			seg_left = 0;
			next_id = 0;
			for (int it = 0; it < phase_items[p]; it++) begin
				// each program opens with a clear; ids grow with small gaps
				if (seg_left == 0) begin
					bits = {$urandom, $urandom, $urandom};
					r = request_t'(bits[$bits(request_t)-1:0]);
					r.cmd = ssacf_pkg::CMD_CLEAR;
					pending_reqs.push_back(r);
					prior_ids.delete();
					seg_left = $urandom_range(15, 60);
					next_id = ($urandom_range(2) == 0 && lim > 40) ?
						int'($urandom_range(lim - 40)) : 0;
				end
				seg_left--;
				bits = {$urandom, $urandom, $urandom};
				r = request_t'(bits[$bits(request_t)-1:0]);
				pick = $urandom_range(99);
				if (next_id > ID_MAX) begin
					pick = 90;
					seg_left = 0;
				end else if (pick >= 4 && pick < 80 && next_id == 0) begin
					pick = 10;
				end
				if (pick < 2) begin
					r.cmd = ssacf_pkg::CMD_W'($urandom_range(1, 7));
				end else if (pick < 4) begin
					// define that names its own or a later id
					r.cmd = (pick == 2) ? ssacf_pkg::CMD_OP : ssacf_pkg::CMD_PHI;
					r.id = ssacf_pkg::ID_W'(next_id);
					r.op_valid = 1'b1;
					r.op = ssacf_pkg::OP_W'($urandom_range(ssacf_pkg::OP_XOR));
					r.count = 2;
					r.opnd[0] = ssacf_pkg::ID_W'(pick_prior(next_id));
					r.opnd[1] = ssacf_pkg::ID_W'(next_id + $urandom_range(3));
				end else if (pick < 30) begin
					r.cmd = ssacf_pkg::CMD_PLAIN;
					r.id = ssacf_pkg::ID_W'(next_id);
					r.has_const = ($urandom_range(7) != 0);
					if ($urandom_range(1))
						r.cval = const_pool[$urandom_range(4)];
				end else if (pick < 60) begin
					r.cmd = ssacf_pkg::CMD_OP;
					r.id = ssacf_pkg::ID_W'(next_id);
					r.op_valid = 1'b1;
					r.op = ssacf_pkg::OP_W'($urandom_range(ssacf_pkg::OP_XOR));
					r.count = 2;
					r.opnd[0] = ssacf_pkg::ID_W'(pick_prior(next_id));
					r.opnd[1] = ssacf_pkg::ID_W'(pick_prior(next_id));
				end else if (pick < 80) begin
					r.cmd = ssacf_pkg::CMD_PHI;
					r.id = ssacf_pkg::ID_W'(next_id);
					r.count = ($urandom_range(9) == 0) ?
						ssacf_pkg::CNT_W'($urandom_range(7)) :
						ssacf_pkg::CNT_W'($urandom_range(1, MAX_OPND));
					r.opnd[0] = ssacf_pkg::ID_W'(pick_prior(next_id));
					for (int k = 1; k < ssacf_pkg::PHI_FIELDS; k++)
						r.opnd[k] = $urandom_range(1) ? r.opnd[0] :
							ssacf_pkg::ID_W'(pick_prior(next_id));
				end else begin
					r.cmd = ssacf_pkg::CMD_READ;
					if (prior_ids.size() != 0 && $urandom_range(3) != 0)
						r.id = ssacf_pkg::ID_W'(prior_ids[$urandom_range(prior_ids.size() - 1)]);
				end
				if (pick >= 2 && pick < 80) begin
					prior_ids.push_back(next_id);
					next_id += 1 + (($urandom_range(7) == 0) ? int'($urandom_range(1, 3)) : 0);
				end
				pending_reqs.push_back(r);
			end
			wait_table_idle();
		end

		repeat (20) @(posedge clk);
		if (n_bad == 0 && expected_entries.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
hw/rtl/ssacf_pkg.sv
hw/rtl/ssacf_ram.sv
hw/rtl/ssa_constant_folding_table.sv
dv/ssa_constant_folding_table_tb.sv
